[hdl/assert_macros.svh]
// Assertion helper macros used by the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define AST_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rfm check failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rfm check failed: next-cycle implication");

`endif

[hdl/rfm_pkg.sv]
// Shared constants and controller/datapath interface types of the frequency meter.
// No dependencies.
`timescale 1ns / 1ps

package rfm_pkg;

    localparam int CNT_W      = 16;
    localparam int REF_W      = 24;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 32;
    localparam int STEP_W     = $clog2(REF_W);

    localparam logic [REF_W-1:0] REF_RESET = REF_W'(8000000);

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_WAITING = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;        // an input transaction completes this cycle
        logic capture_first; // record the counter at the first rising edge
        logic clear_count;   // restart the tick counter after a result
        logic start_div;     // load the divider
        logic div_step;      // one divider iteration
        logic div_finish;    // last iteration, load the output register
        logic load_wrap;     // load a waiting result into the output register
    } rfm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rise;
        logic fall;
        logic ordered;       // first capture below the current count
        logic div_last;      // divider is on its last iteration
        logic out_full;      // output register holds an untaken result
    } rfm_stat_t;

endpackage

[hdl/rfm_ctrl.sv]
// Measurement controller: tracks edge phases and sequences the divider.
// Depends on rfm_pkg.
`timescale 1ns / 1ps

module rfm_ctrl
    import rfm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  rfm_stat_t stat,
    output rfm_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_RISE1 = 4'b0001,
        ST_FALL  = 4'b0010,
        ST_RISE2 = 4'b0100,
        ST_DIV   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // A closing edge needs a free output register, so only the second-rise
    // phase stalls on a full output.
    assign s_tready = (state_reg != ST_DIV) && !((state_reg == ST_RISE2) && stat.out_full);

    always_comb
    begin
        state_next        = state_reg;
        cmd               = '0;
        cmd.accept        = s_tvalid && s_tready;
        unique case (state_reg)
            ST_RISE1:
            begin
                if (cmd.accept && stat.rise)
                begin
                    cmd.capture_first = 1'b1;
                    state_next        = ST_FALL;
                end
            end
            ST_FALL:
            begin
                if (cmd.accept && stat.fall)
                begin
                    state_next = ST_RISE2;
                end
            end
            ST_RISE2:
            begin
                if (cmd.accept && stat.rise)
                begin
                    cmd.clear_count = 1'b1;
                    if (stat.ordered)
                    begin
                        cmd.start_div = 1'b1;
                        state_next    = ST_DIV;
                    end
                    else
                    begin
                        cmd.load_wrap = 1'b1;
                        state_next    = ST_RISE1;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    cmd.div_finish = 1'b1;
                    state_next     = ST_RISE1;
                end
            end
            default:
            begin
                state_next = ST_RISE1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RISE1;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/rfm_datapath.sv]
// Datapath: tick counter, edge capture, restoring divider and output register.
// Depends on rfm_pkg.
`timescale 1ns / 1ps

module rfm_datapath
    import rfm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  level,
    input  logic                  cfg_we,
    input  logic [REF_W-1:0]      cfg_wdata,
    input  rfm_cmd_t              cmd,
    output rfm_stat_t             stat,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [REF_W-1:0]      freq,
    output logic                  status
);

    logic [REF_W-1:0]  ref_reg;
    logic [CNT_W-1:0]  tick_reg;
    logic [CNT_W-1:0]  first_reg;
    logic              prev_reg;
    logic [CNT_W-1:0]  divisor_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [REF_W-1:0]  quot_reg;
    logic [STEP_W-1:0] step_reg;
    logic              out_valid_reg;
    logic [REF_W-1:0]  out_freq_reg;
    logic              out_status_reg;

    logic [CNT_W:0]    rem_shift;
    logic              q_bit;
    logic [CNT_W-1:0]  rem_next;
    logic [REF_W-1:0]  quot_next;

    assign stat.rise     = level && !prev_reg;
    assign stat.fall     = !level && prev_reg;
    assign stat.ordered  = first_reg < tick_reg;
    assign stat.div_last = (step_reg == '0);
    assign stat.out_full = out_valid_reg;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb
    begin
        rem_shift = {rem_reg, quot_reg[REF_W-1]};
        q_bit     = (rem_shift >= {1'b0, divisor_reg});
        if (q_bit)
        begin
            rem_next = CNT_W'(rem_shift - {1'b0, divisor_reg});
        end
        else
        begin
            rem_next = rem_shift[CNT_W-1:0];
        end
        quot_next = {quot_reg[REF_W-2:0], q_bit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg       <= REF_RESET;
            tick_reg      <= '0;
            first_reg     <= '0;
            prev_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ref_reg <= cfg_wdata;
            end
            if (cmd.accept)
            begin
                prev_reg <= level;
                tick_reg <= cmd.clear_count ? '0 : tick_reg + 1'b1;
            end
            if (cmd.capture_first)
            begin
                first_reg <= tick_reg;
            end
            if (cmd.load_wrap || cmd.div_finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_div)
        begin
            divisor_reg <= tick_reg - first_reg;
            rem_reg     <= '0;
            quot_reg    <= ref_reg;
            step_reg    <= STEP_W'(REF_W - 1);
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
            step_reg <= step_reg - 1'b1;
        end
        if (cmd.div_finish)
        begin
            out_freq_reg   <= quot_next;
            out_status_reg <= STATUS_OK;
        end
        else if (cmd.load_wrap)
        begin
            out_freq_reg   <= '0;
            out_status_reg <= STATUS_WAITING;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign freq     = out_freq_reg;
    assign status   = out_status_reg;

endmodule

[hdl/reciprocal_frequency_meter.sv]
// Reciprocal frequency meter: one result per measured period; one input transaction
// per cycle, held while the divider runs and in the second-rise phase while a result
// is untaken. The closing rising edge loads the divider, which runs one restoring
// iteration per quotient bit, the last loading the output register; a wrapped result
// appears in the cycle after the closing edge. Reset (rst_n, async, active low) clears
// the counter, phase, captures and sets reference_hz to 8000000.
`timescale 1ns / 1ps

module reciprocal_frequency_meter
    import rfm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [0] signal_level, [7:1] zero
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [23:0] frequency_hz, [24] status, [31:25] zero
    // Configuration: reference_hz.
    input  logic                  cfg_we,
    input  logic [REF_W-1:0]      cfg_wdata
);

    rfm_cmd_t         cmd;
    rfm_stat_t        stat;
    logic [REF_W-1:0] freq;
    logic             status;

    // The controller walks the edge phases of a measurement (first rise, fall,
    // second rise) and then holds the input stream while the divider runs.
    rfm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath owns the tick counter, the first-edge capture, the reference
    // register, the divider and the output register, which lets new samples flow
    // while a result waits to be taken, except in the second-rise phase.
    rfm_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .level     (s_tdata[0]),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .freq      (freq),
        .status    (status)
    );

    assign m_tdata = {(OUT_DATA_W - REF_W - 1)'(0), status, freq};

endmodule

[hdl/rfm_checker.sv]
// Port-level checker for the reciprocal frequency meter, bound to the top level.
// Depends on rfm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rfm_checker
    import rfm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // A waiting result carries a zero frequency.
    `AST_IMPLIES(a_wait_zero, clk, rst_n, m_tvalid && m_tdata[REF_W], m_tdata[REF_W-1:0] == '0)

    // Padding above the status bit stays zero.
    `AST_IMPLIES(a_pad_zero, clk, rst_n, m_tvalid, m_tdata[OUT_DATA_W-1:REF_W+1] == '0)

    // A valid result ends a measurement, so the next cannot follow back to back.
    `AST_NEXT(a_no_burst, clk, rst_n, m_tvalid && m_tready, !m_tvalid)

    // A stalled result holds its contents.
    `AST_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind reciprocal_frequency_meter rfm_checker u_rfm_checker (.*);

[dv/tb.sv]
// Self-checking testbench for reciprocal_frequency_meter: streams sampled levels in,
// predicts every period reading in-line and checks each result transaction.
// Depends on rfm_pkg and the reciprocal_frequency_meter RTL only.
`timescale 1ns / 1ps

module tb
    import rfm_pkg::*;
();

    // Generous ceiling on the run length. A correct run sends a few thousand
    // samples at most and stays well under this ceiling even with the longest
    // sender gaps, divider stalls and receiver stalls.
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    // Cycles allowed after the last reading before the block counts as idle.
    localparam int unsigned SETTLE_CYCLES = 32;

    // Measurement phases of the predictor.
    typedef enum logic [1:0] {
        SEEK_FIRST_RISE  = 2'd0,
        SEEK_FALL        = 2'd1,
        SEEK_SECOND_RISE = 2'd2
    } meter_phase_t;

    // One period reading as carried by the result stream.
    typedef struct packed {
        logic [REF_W-1:0] freq;
        logic             status;
    } reading_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;    // [0] signal_level, [7:1] zero
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;    // [23:0] frequency_hz, [24] status, [31:25] zero
    logic                  cfg_we;
    logic [REF_W-1:0]      cfg_wdata;

    // Predictor state: a private copy of the meter's counter, capture and phase.
    logic [CNT_W-1:0] tick_now;
    logic [CNT_W-1:0] first_capture;
    logic             last_level;
    meter_phase_t     meter_phase;
    logic [REF_W-1:0] ref_hz;

    // Readings that the predictor has computed and the block has not delivered yet.
    reading_t pending_readings[$];

    int unsigned burst_left;
    int unsigned samples_sent;
    int unsigned readings_seen;
    int unsigned readings_ok;
    int unsigned readings_waiting;
    int unsigned reading_errors;
    int unsigned ref_writes;
    int unsigned cycle_count;

    reciprocal_frequency_meter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Run-length watchdog. A hung handshake ends the run here.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles with %0d readings outstanding.",
                         cycle_count, pending_readings.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Advance the predictor by one accepted sample. An edge is a change from the
    // previous sample. The counter value of the sample is the capture. A closing
    // rising edge yields a reading and restarts the counter at zero; otherwise the
    // counter advances by one and wraps at the counter width.
    task automatic track_level(input logic level);
        logic        rise;
        logic        fall;
        logic        done;
        logic [CNT_W-1:0] now;
        reading_t    r;
        begin
            rise = level & ~last_level;
            fall = ~level & last_level;
            now  = tick_now;
            done = 1'b0;
            last_level = level;
            case (meter_phase)
                SEEK_FALL:
                begin
                    if (fall)
                        meter_phase = SEEK_SECOND_RISE;
                end
                SEEK_SECOND_RISE:
                begin
                    if (rise)
                    begin
                        // Equal captures or a capture that wrapped below the
                        // first one give a waiting reading with a zero quotient.
                        if (first_capture < now)
                        begin
                            r.freq   = ref_hz / REF_W'(now - first_capture);
                            r.status = STATUS_OK;
                        end
                        else
                        begin
                            r.freq   = '0;
                            r.status = STATUS_WAITING;
                        end
                        pending_readings.push_back(r);
                        done        = 1'b1;
                        meter_phase = SEEK_FIRST_RISE;
                    end
                end
                default:
                begin
                    meter_phase = SEEK_FIRST_RISE;
                    if (rise)
                    begin
                        first_capture = now;
                        meter_phase   = SEEK_FALL;
                    end
                end
            endcase
            tick_now = done ? '0 : now + 1'b1;
        end
    endtask

    // Send one sample. The sender works in bursts; between bursts it drops
    // tvalid for a random gap, and about a quarter of the bursts follow with no gap.
    // tvalid is left high after the transaction so that bursts run back to back.
    task automatic send_level(input logic level);
        int unsigned gap;
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap != 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 40);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {{(IN_DATA_W-1){1'b0}}, level};
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            track_level(level);
            samples_sent++;
            burst_left--;
        end
    endtask

    // Hold the sender off until every predicted reading has come back, then
    // give the divider time to settle so that the block is surely idle.
    task automatic wait_readings_drained();
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while (pending_readings.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
            burst_left = 0;
        end
    endtask

    // Program reference_hz. Only called after wait_readings_drained.
    task automatic write_reference(input logic [REF_W-1:0] value);
        begin
            cfg_we    <= 1'b1;
            cfg_wdata <= value;
            @(posedge clk);
            cfg_we <= 1'b0;
            ref_hz = value;
            ref_writes++;
        end
    endtask

    // Shortest possible period: rise, fall, rise on consecutive samples. A leading
    // low sample makes the first rise fresh whatever the line level was.
    task automatic measure_short_period();
        begin
            send_level(1'b0);
            send_level(1'b1);
            send_level(1'b0);
            send_level(1'b1);
        end
    endtask

    // Random waveform: mostly runs of alternating level with lengths that favor
    // short periods, sometimes long ones, and bursts of noise between them.
    task automatic send_pulse_train(input int unsigned n);
        int unsigned sent;
        int unsigned run;
        int unsigned pick;
        logic        level;
        begin
            sent = 0;
            while (sent < n)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 12)
                begin
                    run = $urandom_range(1, 8);
                    repeat (run) send_level(1'($urandom_range(0, 1)));
                end
                else
                begin
                    level = ~last_level;
                    if (pick < 70)
                        run = $urandom_range(1, 4);
                    else if (pick < 96)
                        run = $urandom_range(5, 40);
                    else
                        run = $urandom_range(41, 400);
                    repeat (run) send_level(level);
                end
                sent += run;
            end
        end
    endtask

    // A high first sample after reset is a rising edge at tick zero, so
    // high, low, high gives a two-tick period at the reset reference rate.
    task automatic test_high_after_reset();
        begin
            send_level(1'b1);
            send_level(1'b0);
            send_level(1'b1);
        end
    endtask

    // The closing edge of a measurement is consumed: staying high must not
    // start a new one, and a fall while seeking the first rise is ignored.
    task automatic test_edge_consumed();
        begin
            send_level(1'b1);
            send_level(1'b0);
            send_level(1'b1);
            send_level(1'b1);
            send_level(1'b0);
            send_level(1'b0);
            send_level(1'b1);
            send_level(1'b1);
        end
    endtask

    // Largest reference gives the largest quotient; a reference of one over two
    // ticks truncates to zero; zero reference is out of range but still divides.
    task automatic test_reference_extremes();
        begin
            wait_readings_drained();
            write_reference({REF_W{1'b1}});
            measure_short_period();
            wait_readings_drained();
            write_reference(REF_W'(1));
            measure_short_period();
            wait_readings_drained();
            write_reference('0);
            measure_short_period();
            wait_readings_drained();
            write_reference(REF_RESET);
        end
    endtask

    // Bulk random traffic in rounds, reprogramming the reference between rounds
    // once the block has drained. The drain doubles as the full sender pause.
    task automatic test_random_stream();
        int unsigned pick;
        begin
            for (int round = 0; round < 6; round++)
            begin
                wait_readings_drained();
                pick = $urandom_range(0, 7);
                if (pick == 0)
                    write_reference({REF_W{1'b1}});
                else if (pick == 1)
                    write_reference(REF_W'($urandom_range(0, 255)));
                else
                    write_reference(REF_W'($urandom_range(0, 24'hFFFFFF)));
                send_pulse_train(230);
            end
        end
    endtask

    // Result receiver: the ready pattern moves between always ready, a coin
    // toss per cycle, and alternating stall and ready runs of random length.
    initial
    begin
        int unsigned mode_left;
        int unsigned mode;
        int unsigned hold;
        logic        ready_now;
        mode_left = 0;
        mode      = 0;
        hold      = 0;
        ready_now = 1'b0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(50, 200);
            end
            mode_left--;
            case (mode)
                0: ready_now = 1'b1;
                1: ready_now = 1'($urandom_range(0, 1));
                default:
                begin
                    if (hold == 0)
                    begin
                        ready_now = ~ready_now;
                        hold = ready_now ? $urandom_range(1, 4) : $urandom_range(1, 10);
                    end
                    hold--;
                end
            endcase
            m_tready <= ready_now;
        end
    end

    // Result checker. Each accepted result transaction is compared, field by
    // field, with the oldest predicted reading.
    always @(posedge clk)
    begin : check_readings
        reading_t got;
        reading_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.freq   = m_tdata[REF_W-1:0];
            got.status = m_tdata[REF_W];
            readings_seen++;
            if (got.status == STATUS_OK)
                readings_ok++;
            else
                readings_waiting++;
            if (pending_readings.size() == 0)
            begin
                reading_errors++;
                if (reading_errors <= 10)
                    $display("Unexpected reading at cycle %0d: freq %0d status %0b",
                             cycle_count, got.freq, got.status);
            end
            else
            begin
                want = pending_readings.pop_front();
                if (got.freq !== want.freq || got.status !== want.status)
                begin
                    reading_errors++;
                    if (reading_errors <= 10)
                        $display({"Reading mismatch at cycle %0d: freq %0d/%0d ",
                                  "status %0b/%0b (expected/actual)"},
                                 cycle_count, want.freq, got.freq, want.status,
                                 got.status);
                end
            end
        end
    end

    // Main sequence: reset once, then each test in turn, then the final drain.
    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;

        tick_now         = '0;
        first_capture    = '0;
        last_level       = 1'b0;
        meter_phase      = SEEK_FIRST_RISE;
        ref_hz           = REF_RESET;
        burst_left       = 0;
        samples_sent     = 0;
        readings_seen    = 0;
        readings_ok      = 0;
        readings_waiting = 0;
        reading_errors   = 0;
        ref_writes       = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_high_after_reset();
        test_edge_consumed();
        test_reference_extremes();
        test_random_stream();

        wait_readings_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d samples; checked %0d readings (%0d valid, %0d waiting).",
                 samples_sent, readings_seen, readings_ok, readings_waiting);
        $display("Reference rate programmed %0d times, including zero, one and full scale.",
                 ref_writes);
        if (reading_errors == 0 && pending_readings.size() == 0)
            $display("*** PASSED ***");
        else
        begin
            $display("%0d reading errors, %0d readings never delivered.",
                     reading_errors, pending_readings.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[reciprocal_frequency_meter.f]
+incdir+hdl
hdl/rfm_pkg.sv
hdl/rfm_ctrl.sv
hdl/rfm_datapath.sv
hdl/reciprocal_frequency_meter.sv
hdl/rfm_checker.sv
dv/tb.sv
